// ===== rtl/core/prfl_pkg.sv =====
`default_nettype none
package prfl_pkg;

	localparam int FRAMES_DEF    = 16;
	localparam int PAGE_BITS_DEF = 16;

	// fixed field widths of the ports
	localparam int PAGE_W    = 16;
	localparam int FIU_W     = 5;
	localparam int HIT_W     = 32;
	localparam int CFG_W     = 5;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_FRAMES_IN_USE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POLICY_MODE   = 1'd1;

	localparam logic [FIU_W-1:0] FIU_RESET   = 5'd16;
	localparam logic             POLICY_FIFO = 1'b0;
	localparam logic             POLICY_LRU  = 1'b1;

	// per-word control broadcast to every frame cell
	typedef struct packed {
		logic accept;      // a word is taken this cycle
		logic clear;       // end of trace: drop all frames after this word
		logic allow_move;  // miss, or hit under LRU
	} cell_ctl_t;

endpackage
`default_nettype wire

// ===== rtl/core/prfl_cell.sv =====
`default_nettype none
module prfl_cell #(
	parameter int PAGE_BITS = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire prfl_pkg::cell_ctl_t ctl,
	input  wire [PAGE_BITS-1:0]   ref_page,
	input  wire                   active,
	input  wire                   is_last,
	input  wire [PAGE_BITS-1:0]   prev_page,
	input  wire                   prev_valid,
	input  wire                   ahead_in,
	input  wire                   ev_valid_in,
	input  wire [PAGE_BITS-1:0]   ev_page_in,
	output logic [PAGE_BITS-1:0]  page,
	output logic                  valid,
	output logic                  ahead_out,
	output logic                  ev_valid_out,
	output logic [PAGE_BITS-1:0]  ev_page_out
);
	import prfl_pkg::*;

	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q;
	logic                 match;
	logic                 shift;

	assign match     = valid_q & active & (page_q == ref_page);
	assign ahead_out = ahead_in | match;
	// on an LRU hit, cells up to and including the hit (or all active cells on a miss) take the neighbor's frame
	assign shift     = ctl.accept & ctl.allow_move & active & ~ahead_in;

	assign ev_valid_out = is_last ? valid_q : ev_valid_in;
	assign ev_page_out  = is_last ? page_q : ev_page_in;

	assign page  = page_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.accept && ctl.clear) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= prev_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (shift) begin
			page_q <= prev_page;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/page_replacement_fifo_lru_unit.sv =====
`default_nettype none
// channel  direction  handshake                 payload
// req      in         req_valid / req_stall     page_number, end_of_trace
// rsp      out        rsp_valid / rsp_stall     hit, evicted_valid, evicted_page, hit_total
// cfg      in         cfg_we                    cfg_index, cfg_data
//
// One word per cycle unless stalled; the result enters rsp the cycle after acceptance.
// Cycle time is set by the page compare and the priority ripple through the FRAMES cells.
// Reset clears all frame valid bits, the hit count and rsp_valid; config returns
// to 16 frames, FIFO policy.
// req_stall follows rsp_valid & rsp_stall: a word is taken whenever the rsp register
// is empty or drains in the same cycle.
module page_replacement_fifo_lru_unit #(
	parameter int FRAMES    = prfl_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = prfl_pkg::PAGE_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire [prfl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [prfl_pkg::CFG_W-1:0]        cfg_data,
	input  wire                              req_valid,
	output logic                             req_stall,
	input  wire [prfl_pkg::PAGE_W-1:0]       page_number,
	input  wire                              end_of_trace,
	output logic                             rsp_valid,
	input  wire                              rsp_stall,
	output logic                             hit,
	output logic                             evicted_valid,
	output logic [prfl_pkg::PAGE_W-1:0]      evicted_page,
	output logic [prfl_pkg::HIT_W-1:0]       hit_total
);
	import prfl_pkg::*;

	localparam int NW = ($clog2(FRAMES + 1) > FIU_W) ? $clog2(FRAMES + 1) : FIU_W;

	logic [FIU_W-1:0]     fiu_q;
	logic                 policy_q;
	logic [NW-1:0]        fiu_ext;
	logic [NW-1:0]        n_eff;
	logic                 accept;
	logic [PAGE_BITS-1:0] ref_page;
	cell_ctl_t            ctl;

	logic [PAGE_BITS-1:0] page_chain  [0:FRAMES];
	logic                 valid_chain [0:FRAMES];
	logic                 ahead_chain [0:FRAMES];
	logic                 evv_chain   [0:FRAMES];
	logic [PAGE_BITS-1:0] evp_chain   [0:FRAMES];

	logic                 hit_now;
	logic                 ev_now;
	logic [PAGE_W-1:0]    ev_page_tr;
	logic [HIT_W-1:0]     cnt_q;
	logic [HIT_W-1:0]     cnt_next;

	logic                 rsp_valid_q;
	logic                 hit_q;
	logic                 ev_valid_q;
	logic [PAGE_W-1:0]    ev_page_q;
	logic [HIT_W-1:0]     hit_total_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fiu_q    <= FIU_RESET;
			policy_q <= POLICY_FIFO;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAMES_IN_USE: fiu_q    <= cfg_data[FIU_W-1:0];
				REG_POLICY_MODE:   policy_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// clamp frame count to 1..FRAMES
	assign fiu_ext = NW'(fiu_q);
	always_comb begin
		if (fiu_ext == '0) begin
			n_eff = NW'(1);
		end else if (fiu_ext > NW'(FRAMES)) begin
			n_eff = NW'(FRAMES);
		end else begin
			n_eff = fiu_ext;
		end
	end

	generate
		if (PAGE_BITS <= PAGE_W) begin : g_in_narrow
			assign ref_page = page_number[PAGE_BITS-1:0];
		end else begin : g_in_wide
			assign ref_page = {{(PAGE_BITS - PAGE_W){1'b0}}, page_number};
		end
	endgenerate

	assign req_stall = rsp_valid_q & rsp_stall;
	assign accept    = req_valid & ~req_stall;

	assign ctl.accept     = accept;
	assign ctl.clear      = end_of_trace;
	assign ctl.allow_move = (policy_q == POLICY_LRU) | ~hit_now;

	// the new page enters at the front
	assign page_chain[0]  = ref_page;
	assign valid_chain[0] = 1'b1;
	assign ahead_chain[0] = 1'b0;
	assign evv_chain[0]   = 1'b0;
	assign evp_chain[0]   = '0;

	generate
		for (genvar i = 0; i < FRAMES; i++) begin : g_cell
			logic act;
			logic last;
			assign act  = n_eff > NW'(i);
			assign last = n_eff == NW'(i + 1);

			prfl_cell #(
				.PAGE_BITS (PAGE_BITS)
			) u_cell (
				.clk          (clk),
				.arst_n       (arst_n),
				.ctl          (ctl),
				.ref_page     (ref_page),
				.active       (act),
				.is_last      (last),
				.prev_page    (page_chain[i]),
				.prev_valid   (valid_chain[i]),
				.ahead_in     (ahead_chain[i]),
				.ev_valid_in  (evv_chain[i]),
				.ev_page_in   (evp_chain[i]),
				.page         (page_chain[i+1]),
				.valid        (valid_chain[i+1]),
				.ahead_out    (ahead_chain[i+1]),
				.ev_valid_out (evv_chain[i+1]),
				.ev_page_out  (evp_chain[i+1])
			);
		end
	endgenerate

	assign hit_now = ahead_chain[FRAMES];
	assign ev_now  = ~hit_now & evv_chain[FRAMES];

	generate
		if (PAGE_BITS >= PAGE_W) begin : g_ev_wide
			assign ev_page_tr = evp_chain[FRAMES][PAGE_W-1:0];
		end else begin : g_ev_narrow
			assign ev_page_tr = {{(PAGE_W - PAGE_BITS){1'b0}}, evp_chain[FRAMES]};
		end
	endgenerate

	assign cnt_next = (hit_now && !(&cnt_q)) ? cnt_q + HIT_W'(1) : cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (accept) begin
			cnt_q <= end_of_trace ? '0 : cnt_next;
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			hit_q       <= hit_now;
			ev_valid_q  <= ev_now;
			ev_page_q   <= ev_now ? ev_page_tr : '0;
			hit_total_q <= cnt_next;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign hit           = hit_q;
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign hit_total     = hit_total_q;

endmodule
`default_nettype wire

// ===== verif/page_replacement_fifo_lru_checker.sv =====
`timescale 1ns / 100ps
module page_replacement_fifo_lru_checker (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire [prfl_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire [prfl_pkg::CFG_W-1:0]        cfg_data,
	input  wire                              req_valid,
	input  wire                              req_stall,
	input  wire [prfl_pkg::PAGE_W-1:0]       page_number,
	input  wire                              end_of_trace,
	input  wire                              rsp_valid,
	input  wire                              rsp_stall,
	input  wire                              hit,
	input  wire                              evicted_valid,
	input  wire [prfl_pkg::PAGE_W-1:0]       evicted_page,
	input  wire [prfl_pkg::HIT_W-1:0]        hit_total,
	output int                               fail_count,
	output int                               outstanding
);
	import prfl_pkg::*;

	typedef struct packed {
		logic              hit;
		logic              evicted_valid;
		logic [PAGE_W-1:0] evicted_page;
		logic [HIT_W-1:0]  hit_total;
	} page_result_t;

	logic [PAGE_W-1:0] frame_page [FRAMES_DEF];
	logic              frame_valid [FRAMES_DEF];
	logic [HIT_W-1:0]  hit_count;
	logic [FIU_W-1:0]  frames_reg;
	logic              policy_reg;
	page_result_t      expected_q [$];

	// one reference against the resident list; updates frames and hit count
	function automatic page_result_t predict_reference(input logic [PAGE_W-1:0] pg,
			input logic last_ref);
		page_result_t r;
		int n;
		int slot;
		int i;
		r = '0;
		n = int'(frames_reg);
		if (n < 1) n = 1;
		if (n > FRAMES_DEF) n = FRAMES_DEF;
		slot = -1;
		// nearest the front wins when a page is resident twice
		for (i = 0; i < n; i++)
			if (slot < 0 && frame_valid[i] && frame_page[i] == pg) slot = i;
		if (slot >= 0) begin
			r.hit = 1'b1;
			if (hit_count != '1) hit_count = hit_count + HIT_W'(1);
			if (policy_reg == POLICY_LRU) begin
				for (i = slot; i > 0; i--) begin
					frame_page[i] = frame_page[i-1];
					frame_valid[i] = frame_valid[i-1];
				end
				frame_page[0] = pg;
				frame_valid[0] = 1'b1;
			end
		end else begin
			if (frame_valid[n-1]) begin
				r.evicted_valid = 1'b1;
				r.evicted_page = frame_page[n-1];
			end
			for (i = n - 1; i > 0; i--) begin
				frame_page[i] = frame_page[i-1];
				frame_valid[i] = frame_valid[i-1];
			end
			frame_page[0] = pg;
			frame_valid[0] = 1'b1;
		end
		r.hit_total = hit_count;
		if (last_ref) begin
			for (i = 0; i < FRAMES_DEF; i++) frame_valid[i] = 1'b0;
			hit_count = '0;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		page_result_t want;
		int errs;
		int i;
		if (!arst_n) begin
			for (i = 0; i < FRAMES_DEF; i++) begin
				frame_valid[i] = 1'b0;
				frame_page[i] = '0;
			end
			hit_count = '0;
			frames_reg = FIU_RESET;
			policy_reg = POLICY_FIFO;
			expected_q.delete();
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			errs = 0;
			if (cfg_we) begin
				if (cfg_index == REG_FRAMES_IN_USE)
					frames_reg = cfg_data[FIU_W-1:0];
				else if (cfg_index == REG_POLICY_MODE)
					policy_reg = cfg_data[0];
			end
			// a result never leaves in the cycle its word is taken, so pop before push
			if (rsp_valid && !rsp_stall) begin
				if (expected_q.size() == 0) begin
					$error("result word with no reference pending");
					errs++;
				end else begin
					want = expected_q.pop_front();
					if (hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, hit);
						errs++;
					end
					if (evicted_valid !== want.evicted_valid) begin
						$error("evicted_valid: expected %0d, got %0d",
							want.evicted_valid, evicted_valid);
						errs++;
					end
					if (evicted_page !== want.evicted_page) begin
						$error("evicted_page: expected %h, got %h",
							want.evicted_page, evicted_page);
						errs++;
					end
					if (hit_total !== want.hit_total) begin
						$error("hit_total: expected %0d, got %0d",
							want.hit_total, hit_total);
						errs++;
					end
				end
			end
			if (req_valid && !req_stall)
				expected_q.push_back(predict_reference(page_number, end_of_trace));
			fail_count <= fail_count + errs;
			outstanding <= expected_q.size();
		end
	end

endmodule

// ===== verif/tb_page_replacement_fifo_lru_unit.sv =====
`timescale 1ns / 100ps
module tb_page_replacement_fifo_lru_unit;
	import prfl_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int RAND_PHASES = 12;
	localparam int PHASE_WORDS = 96;
	localparam int FRAME_PICKS [11] = '{1, 16, 0, 31, 2, 3, 4, 8, 15, 17, 5};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 req_valid = 1'b0;
	logic [PAGE_W-1:0]    page_number = '0;
	logic                 end_of_trace = 1'b0;
	logic                 rsp_stall = 1'b0;
	logic                 req_stall;
	logic                 rsp_valid;
	logic                 hit;
	logic                 evicted_valid;
	logic [PAGE_W-1:0]    evicted_page;
	logic [HIT_W-1:0]     hit_total;
	int                   fail_count;
	int                   outstanding;
	int                   cycle_count = 0;

	page_replacement_fifo_lru_unit uut (.*);
	page_replacement_fifo_lru_checker checker_i (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver: free flow, random stalls, then a long hold-off that backs up the input
	initial begin
		forever begin
			repeat ($urandom_range(50, 200)) begin
				@(posedge clk);
				rsp_stall <= 1'b0;
			end
			repeat ($urandom_range(100, 300)) begin
				@(posedge clk);
				rsp_stall <= ($urandom_range(0, 99) < 35);
			end
			repeat ($urandom_range(40, 80)) begin
				@(posedge clk);
				rsp_stall <= 1'b1;
			end
		end
	end

	task automatic send_word(input logic [PAGE_W-1:0] pg, input logic last_ref);
		req_valid <= 1'b1;
		page_number <= pg;
		end_of_trace <= last_ref;
		do @(posedge clk); while (req_stall);
	endtask

	task automatic idle_cycles(input int n);
		req_valid <= 1'b0;
		page_number <= PAGE_W'($urandom);
		end_of_trace <= 1'($urandom_range(0, 1));
		repeat (n) @(posedge clk);
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [PAGE_W-1:0] page_pool [32];
		logic [PAGE_W-1:0] pg;
		logic              last_ref;
		int                ph;
		int                i;
		int                ws;
		int                trace_left;
		int                burst_left;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// page 0 must not match empty frames
		send_word(16'h0000, 1'b0);
		send_word(16'h0000, 1'b0);
		send_word(16'hFFFF, 1'b0);
		send_word(16'hFFFF, 1'b1);

		write_reg(REG_FRAMES_IN_USE, 5'd1);
		send_word(16'h0000, 1'b0);
		send_word(16'hFFFF, 1'b0);
		send_word(16'hFFFF, 1'b0);
		send_word(16'h0000, 1'b0);
		send_word(16'hAAAA, 1'b1);

		// LRU evicts the stale page, not the oldest one; upper data bits are don't-care
		write_reg(REG_FRAMES_IN_USE, 5'd3);
		write_reg(REG_POLICY_MODE, 5'b11111);
		send_word(16'h0001, 1'b0);
		send_word(16'h0002, 1'b0);
		send_word(16'h0003, 1'b0);
		send_word(16'h0001, 1'b0);
		send_word(16'h0004, 1'b0);
		send_word(16'h0003, 1'b0);
		send_word(16'h0005, 1'b1);

		// zero frames behaves as one
		write_reg(REG_FRAMES_IN_USE, 5'd0);
		send_word(16'h0007, 1'b0);
		send_word(16'h0007, 1'b0);
		send_word(16'h0008, 1'b1);

		// count above the frame total saturates; shrink then regrow leaves a duplicate
		write_reg(REG_FRAMES_IN_USE, 5'd31);
		write_reg(REG_POLICY_MODE, 5'b00000);
		send_word(16'h5555, 1'b0);
		send_word(16'h1234, 1'b0);
		write_reg(REG_FRAMES_IN_USE, 5'd1);
		send_word(16'h5555, 1'b0);
		write_reg(REG_FRAMES_IN_USE, 5'd2);
		send_word(16'h5555, 1'b1);

		for (ph = 0; ph < RAND_PHASES; ph++) begin
			write_reg(REG_FRAMES_IN_USE,
				(ph < 11) ? CFG_W'(FRAME_PICKS[ph]) : CFG_W'($urandom_range(0, 31)));
			write_reg(REG_POLICY_MODE, {4'($urandom), 1'(ph % 2)});
			for (i = 0; i < 32; i++) page_pool[i] = PAGE_W'($urandom);
			ws = $urandom_range(2, 24);
			trace_left = $urandom_range(5, 60);
			burst_left = $urandom_range(1, 24);
			for (i = 0; i < PHASE_WORDS; i++) begin
				// mostly a small working set so hits and evictions both happen
				if ($urandom_range(0, 99) < 85)
					pg = page_pool[$urandom_range(0, ws - 1)];
				else
					pg = PAGE_W'($urandom);
				trace_left--;
				last_ref = (trace_left == 0) || ($urandom_range(0, 99) == 0);
				if (last_ref) trace_left = $urandom_range(5, 60);
				send_word(pg, last_ref);
				burst_left--;
				if (burst_left == 0) begin
					idle_cycles($urandom_range(1, 6));
					burst_left = $urandom_range(1, 24);
				end
			end
		end

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
